[rtl/core/lei_pkg.sv]
// Shared widths, control word types and the step program of the Lorenz integrator.
package lei_pkg;

  // Fixed field widths.
  localparam int CW        = 32;  // coordinate and coefficient width
  localparam int STEP_W    = 24;  // time step width, fraction of one
  localparam int MUL_W     = 33;  // multiplier operand width
  localparam int PROD_W    = 2 * MUL_W;
  localparam int CFG_IDX_W = 3;
  localparam int PC_W      = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIGMA   = 3'd0,
    REG_RHO     = 3'd1,
    REG_BETA    = 3'd2,
    REG_START_X = 3'd3,
    REG_START_Y = 3'd4,
    REG_START_Z = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [CW-1:0] sigma;
    logic signed [CW-1:0] rho;
    logic signed [CW-1:0] beta;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
  } cfg_t;

  // Control word fields.
  typedef enum logic [2:0] {
    OPA_NONE, OPA_SIGMA, OPA_X, OPA_BETA, OPA_RLO, OPA_RHI
  } opa_sel_t;

  typedef enum logic [2:0] {
    OPB_NONE, OPB_YMX, OPB_RMZ, OPB_Y, OPB_Z, OPB_DT
  } opb_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD_HI
  } acc_op_t;

  typedef enum logic [1:0] {
    RATE_HOLD, RATE_PROD, RATE_PROD_MY, RATE_ACC_MP
  } rate_op_t;

  typedef enum logic [2:0] {
    WR_NONE, WR_TX, WR_TY, WR_TZ, WR_START
  } wr_sel_t;

  typedef enum logic [1:0] {
    SEQ_NEXT, SEQ_WAIT_IN, SEQ_WAIT_OUT, SEQ_JUMP
  } seq_op_t;

  typedef struct packed {
    opa_sel_t         opa;
    opb_sel_t         opb;
    acc_op_t          acc;
    rate_op_t         rate;
    wr_sel_t          wr;
    seq_op_t          seq;
    logic [PC_W-1:0]  target;
  } ucode_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    ucode_t w;
    logic   take;    // input transfer this cycle
    logic   commit;  // result moves to the output register
  } dp_ctrl_t;

  // Status seen by the sequencer.
  typedef struct packed {
    logic in_valid;
    logic restart;
    logic out_free;
  } seq_stat_t;

  // Program entry points.
  localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_COMMIT = PC_W'(20);
  localparam logic [PC_W-1:0] PC_LOAD   = PC_W'(21);

  // Step program. The operands chosen in a step are registered, then the product is registered.
  function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
    ucode_t w;
    w.opa    = OPA_NONE;
    w.opb    = OPB_NONE;
    w.acc    = ACC_HOLD;
    w.rate   = RATE_HOLD;
    w.wr     = WR_NONE;
    w.seq    = SEQ_NEXT;
    w.target = PC_IDLE;
    case (pc)
      5'd0: begin
        w.seq    = SEQ_WAIT_IN;
        w.target = PC_LOAD;
      end
      // x rate: sigma * (y - x)
      5'd1: begin
        w.opa = OPA_SIGMA;
        w.opb = OPB_YMX;
      end
      5'd2: ;
      5'd3: w.rate = RATE_PROD;
      5'd4: begin
        w.opa = OPA_RLO;
        w.opb = OPB_DT;
      end
      5'd5: begin
        w.opa = OPA_RHI;
        w.opb = OPB_DT;
      end
      // y rate product starts while x is scaled.
      5'd6: begin
        w.acc = ACC_LOAD;
        w.opa = OPA_X;
        w.opb = OPB_RMZ;
      end
      5'd7: w.acc = ACC_ADD_HI;
      5'd8: begin
        w.wr   = WR_TX;
        w.rate = RATE_PROD_MY;
      end
      5'd9: begin
        w.opa = OPA_RLO;
        w.opb = OPB_DT;
      end
      5'd10: begin
        w.opa = OPA_RHI;
        w.opb = OPB_DT;
      end
      // z rate products start while y is scaled.
      5'd11: begin
        w.acc = ACC_LOAD;
        w.opa = OPA_X;
        w.opb = OPB_Y;
      end
      5'd12: begin
        w.acc = ACC_ADD_HI;
        w.opa = OPA_BETA;
        w.opb = OPB_Z;
      end
      5'd13: begin
        w.wr  = WR_TY;
        w.acc = ACC_LOAD;
      end
      5'd14: w.rate = RATE_ACC_MP;
      5'd15: begin
        w.opa = OPA_RLO;
        w.opb = OPB_DT;
      end
      5'd16: begin
        w.opa = OPA_RHI;
        w.opb = OPB_DT;
      end
      5'd17: w.acc = ACC_LOAD;
      5'd18: w.acc = ACC_ADD_HI;
      5'd19: w.wr = WR_TZ;
      5'd20: begin
        w.seq    = SEQ_WAIT_OUT;
        w.target = PC_IDLE;
      end
      5'd21: begin
        w.wr     = WR_START;
        w.seq    = SEQ_JUMP;
        w.target = PC_COMMIT;
      end
      default: begin
        w.seq    = SEQ_JUMP;
        w.target = PC_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

[rtl/core/lei_in_if.sv]
// Input channel carrying one time step request.
interface lei_in_if import lei_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STEP_W-1:0] step_size;
  logic              restart;

  modport source (output valid, output step_size, output restart, input ready);
  modport sink (input valid, input step_size, input restart, output ready);
endinterface

[rtl/core/lei_out_if.sv]
// Output channel carrying one new position.
interface lei_out_if import lei_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] pos_x;
  logic signed [CW-1:0] pos_y;
  logic signed [CW-1:0] pos_z;
  logic                 saturated;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output saturated, input ready);
  modport sink (input valid, input pos_x, input pos_y, input pos_z,
                input saturated, output ready);
endinterface

[rtl/core/lei_cfg.sv]
// Coefficient and start position registers with their reset values.
module lei_cfg import lei_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output cfg_t                 cfg
);

  // Reset values; coefficients that do not fit clip to the largest value.
  localparam logic signed [63:0] ONE      = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] I32_MAX  = 64'sd2147483647;
  localparam logic signed [63:0] SIGMA_W  = 64'sd10 * ONE;
  localparam logic signed [63:0] RHO_W    = 64'sd28 * ONE;
  localparam logic signed [63:0] BETA_W   = (64'sd16 * ONE + 64'sd3) / 64'sd6;
  localparam logic signed [63:0] SIGMA_C  = (SIGMA_W > I32_MAX) ? I32_MAX : SIGMA_W;
  localparam logic signed [63:0] RHO_C    = (RHO_W > I32_MAX) ? I32_MAX : RHO_W;
  localparam logic signed [63:0] BETA_C   = (BETA_W > I32_MAX) ? I32_MAX : BETA_W;

  // Register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sigma   <= SIGMA_C[CW-1:0];
      cfg.rho     <= RHO_C[CW-1:0];
      cfg.beta    <= BETA_C[CW-1:0];
      cfg.start_x <= ONE[CW-1:0];
      cfg.start_y <= ONE[CW-1:0];
      cfg.start_z <= ONE[CW-1:0];
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_SIGMA:   cfg.sigma   <= cfg_data;
        REG_RHO:     cfg.rho     <= cfg_data;
        REG_BETA:    cfg.beta    <= cfg_data;
        REG_START_X: cfg.start_x <= cfg_data;
        REG_START_Y: cfg.start_y <= cfg_data;
        REG_START_Z: cfg.start_z <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[rtl/core/lei_seq.sv]
// Step counter and program table that drive the datapath.
module lei_seq import lei_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  seq_stat_t stat,
  output logic      in_ready,
  output dp_ctrl_t  ctrl
);

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  ucode_t          w;

  // No input transfer is taken while reset is held.
  assign w           = ucode_rom(pc);
  assign in_ready    = (w.seq == SEQ_WAIT_IN) && !rst;
  assign ctrl.w      = w;
  assign ctrl.take   = in_ready && stat.in_valid;
  assign ctrl.commit = (w.seq == SEQ_WAIT_OUT) && stat.out_free;

  // Next step, with the waits and jumps of the program.
  always_comb begin
    pc_next = pc;
    case (w.seq)
      SEQ_NEXT: pc_next = pc + PC_W'(1);
      SEQ_WAIT_IN: begin
        if (stat.in_valid) begin
          pc_next = stat.restart ? w.target : pc + PC_W'(1);
        end
      end
      SEQ_WAIT_OUT: begin
        if (stat.out_free) begin
          pc_next = w.target;
        end
      end
      SEQ_JUMP: pc_next = w.target;
      default: pc_next = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/core/lei_mul.sv]
// Shared signed multiplier with a registered product.
module lei_mul import lei_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  opa,
  input  logic signed [MUL_W-1:0]  opb,
  output logic signed [PROD_W-1:0] prod
);

  always_ff @(posedge clk) begin
    prod <= opa * opb;
  end

endmodule

[rtl/core/lei_dp.sv]
// Datapath: position state, operand selection, rate and scaling arithmetic.
module lei_dp import lei_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cfg_t                 cfg,
  input  dp_ctrl_t             ctrl,
  input  logic [STEP_W-1:0]    step_size,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_free,
  output logic signed [CW-1:0] pos_x,
  output logic signed [CW-1:0] pos_y,
  output logic signed [CW-1:0] pos_z,
  output logic                 saturated
);

  // Rate width after scaling back, accumulator wide enough for rate * dt.
  localparam int RATE_W = PROD_W - FRAC_BITS;
  localparam int HI_W   = RATE_W - CW;
  localparam int ACC_W  = (RATE_W + STEP_W + 1 > PROD_W) ? RATE_W + STEP_W + 1 : PROD_W;
  localparam int SUM_W  = ACC_W - STEP_W + 1;

  localparam logic signed [CW-1:0]    ONE     = CW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(32'sh80000000);

  logic signed [CW-1:0]     cur_x, cur_y, cur_z;
  logic signed [CW-1:0]     tx, ty, tz;
  logic                     tsat;
  logic [STEP_W-1:0]        dt;
  logic signed [MUL_W-1:0]  opa, opb;
  logic signed [MUL_W-1:0]  opa_next, opb_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_next;
  logic signed [RATE_W-1:0] rate;
  logic signed [RATE_W-1:0] rate_next;

  logic signed [ACC_W-1:0]  prod_acc;
  logic signed [PROD_W-1:0] prod_sh;
  logic signed [PROD_W-1:0] prod_my;
  logic signed [ACC_W-1:0]  acc_mp;
  logic signed [ACC_W-1:0]  acc_mp_sh;
  logic signed [ACC_W-1:0]  acc_sh;
  logic signed [CW-1:0]     coord;
  logic signed [SUM_W-1:0]  sum;
  logic signed [CW-1:0]     sat_val;
  logic                     sat_hit;

  assign out_free = !out_valid || out_ready;

  lei_mul u_mul (
    .clk  (clk),
    .opa  (opa),
    .opb  (opb),
    .prod (prod)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    opa_next = opa;
    case (ctrl.w.opa)
      OPA_SIGMA: opa_next = MUL_W'(cfg.sigma);
      OPA_X:     opa_next = MUL_W'(cur_x);
      OPA_BETA:  opa_next = MUL_W'(cfg.beta);
      OPA_RLO:   opa_next = {1'b0, rate[CW-1:0]};
      OPA_RHI:   opa_next = {{(MUL_W - HI_W){rate[RATE_W-1]}}, rate[RATE_W-1:CW]};
      default:   opa_next = opa;
    endcase
    opb_next = opb;
    case (ctrl.w.opb)
      OPB_YMX: opb_next = MUL_W'(cur_y) - MUL_W'(cur_x);
      OPB_RMZ: opb_next = MUL_W'(cfg.rho) - MUL_W'(cur_z);
      OPB_Y:   opb_next = MUL_W'(cur_y);
      OPB_Z:   opb_next = MUL_W'(cur_z);
      OPB_DT:  opb_next = {{(MUL_W - STEP_W){1'b0}}, dt};
      default: opb_next = opb;
    endcase
  end

  // Rate forms: scaled product, scaled product minus y, scaled difference.
  assign prod_acc  = ACC_W'(prod);
  assign prod_sh   = prod >>> FRAC_BITS;
  assign prod_my   = prod_sh - PROD_W'(cur_y);
  assign acc_mp    = acc - prod_acc;
  assign acc_mp_sh = acc_mp >>> FRAC_BITS;

  always_comb begin
    rate_next = rate;
    case (ctrl.w.rate)
      RATE_PROD:    rate_next = prod_sh[RATE_W-1:0];
      RATE_PROD_MY: rate_next = prod_my[RATE_W-1:0];
      RATE_ACC_MP:  rate_next = acc_mp_sh[RATE_W-1:0];
      default:      rate_next = rate;
    endcase
  end

  // Accumulator: load a product, such as the low partial product, or add the high one shifted into place.
  always_comb begin
    acc_next = acc;
    case (ctrl.w.acc)
      ACC_LOAD:   acc_next = prod_acc;
      ACC_ADD_HI: acc_next = acc + (prod_acc <<< CW);
      default:    acc_next = acc;
    endcase
  end

  // New coordinate: old value plus floor(rate * dt), clamped to 32 bits.
  assign acc_sh = acc >>> STEP_W;

  always_comb begin
    case (ctrl.w.wr)
      WR_TY:   coord = cur_y;
      WR_TZ:   coord = cur_z;
      default: coord = cur_x;
    endcase
    sum = SUM_W'(acc_sh) + SUM_W'(coord);
    sat_hit = 1'b0;
    if (sum > SUM_MAX) begin
      sat_val = SUM_MAX[CW-1:0];
      sat_hit = 1'b1;
    end else if (sum < SUM_MIN) begin
      sat_val = SUM_MIN[CW-1:0];
      sat_hit = 1'b1;
    end else begin
      sat_val = sum[CW-1:0];
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    opa  <= opa_next;
    opb  <= opb_next;
    acc  <= acc_next;
    rate <= rate_next;
    if (ctrl.take) begin
      dt   <= step_size;
      tsat <= 1'b0;
    end
    case (ctrl.w.wr)
      WR_TX: begin
        tx   <= sat_val;
        tsat <= tsat | sat_hit;
      end
      WR_TY: begin
        ty   <= sat_val;
        tsat <= tsat | sat_hit;
      end
      WR_TZ: begin
        tz   <= sat_val;
        tsat <= tsat | sat_hit;
      end
      WR_START: begin
        tx <= cfg.start_x;
        ty <= cfg.start_y;
        tz <= cfg.start_z;
      end
      default: ;
    endcase
  end

  // Position state and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= ONE;
      cur_y     <= ONE;
      cur_z     <= ONE;
      out_valid <= 1'b0;
    end else if (ctrl.commit) begin
      cur_x     <= tx;
      cur_y     <= ty;
      cur_z     <= tz;
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.commit) begin
      pos_x     <= tx;
      pos_y     <= ty;
      pos_z     <= tz;
      saturated <= tsat;
    end
  end

endmodule

[rtl/core/lorenz_euler_integrator_core.sv]
// Top level of the Lorenz forward Euler integrator.
//
//   channel  direction  transfer moves
//   step     in         step_size, restart
//   result   out        pos_x, pos_y, pos_z, saturated
//   cfg_*    in         one register write per cycle with cfg_we high
//
// A step item runs the step program from its transfer to its result: ten products go
// in turn through the one 33x33 multiplier. A restart item loads the start position.
// Synchronous reset loads the default coefficients and the position 1.0. The result
// sits in an output register, so the next item is taken while it waits; a finished
// result waits for that register to empty.
module lorenz_euler_integrator_core import lei_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst,
  lei_in_if.sink               step,
  lei_out_if.source            result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data
);

  cfg_t      cfg;
  dp_ctrl_t  ctrl;
  seq_stat_t stat;
  logic      out_free;
  logic      in_ready;

  assign stat.in_valid = step.valid;
  assign stat.restart  = step.restart;
  assign stat.out_free = out_free;
  assign step.ready    = in_ready;

  lei_cfg #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lei_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  lei_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .ctrl      (ctrl),
    .step_size (step.step_size),
    .out_ready (result.ready),
    .out_valid (result.valid),
    .out_free  (out_free),
    .pos_x     (result.pos_x),
    .pos_y     (result.pos_y),
    .pos_z     (result.pos_z),
    .saturated (result.saturated)
  );

endmodule

[bench/lorenz_euler_integrator_core_checker.sv]
// Checker for the Lorenz integrator: predicts every new position and compares each result.
`timescale 1ns / 1ps
module lorenz_euler_integrator_core_checker import lei_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  lei_in_if                    step,
  lei_out_if                   result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_data,
  output int                   mismatch_count,
  output int                   outstanding,
  output int                   results_checked,
  output int                   restarts_seen,
  output int                   clamps_seen
);

  localparam int FRAC_BITS = 24;

  typedef logic signed [CW-1:0] coord_t;
  // Wide enough for every product and every rate times dt without overflow.
  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    logic   saturated;
  } position_t;

  localparam wide_t COORD_MAX = (wide_t'(1) <<< (CW - 1)) - wide_t'(1);
  localparam wide_t COORD_MIN = -(wide_t'(1) <<< (CW - 1));

  // Shadow copy of the coefficient and start registers.
  coord_t sigma_r, rho_r, beta_r, start_x_r, start_y_r, start_z_r;
  // Shadow copy of the integrator position.
  coord_t cur_x, cur_y, cur_z;

  position_t expected_positions[$];
  int        errors;
  int        checked_n;
  int        restarts_n;
  int        clamps_n;

  // Clamp a new coordinate to 32 bits and note when it had to be clamped.
  function automatic coord_t clamp_coord(input wide_t v, inout logic hit);
    if (v > COORD_MAX) begin
      hit = 1'b1;
      return coord_t'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      hit = 1'b1;
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

  // Rate times dt, floored toward minus infinity.
  function automatic wide_t scaled_by_dt(input wide_t rate, input wide_t dt);
    return (rate * dt) >>> STEP_W;
  endfunction

  // One forward Euler step of the Lorenz system, or a reload of the start position.
  task automatic euler_advance(input logic [STEP_W-1:0] dt_in, input logic reload,
                               output position_t p);
    wide_t x, y, z, dt, rate_x, rate_y, rate_z;
    logic  hit;
    hit = 1'b0;
    if (reload) begin
      cur_x = start_x_r;
      cur_y = start_y_r;
      cur_z = start_z_r;
    end else begin
      x  = cur_x;
      y  = cur_y;
      z  = cur_z;
      dt = dt_in;
      rate_x = (wide_t'(sigma_r) * (y - x)) >>> FRAC_BITS;
      rate_y = ((x * (wide_t'(rho_r) - z)) >>> FRAC_BITS) - y;
      rate_z = ((x * y) - (wide_t'(beta_r) * z)) >>> FRAC_BITS;
      cur_x = clamp_coord(x + scaled_by_dt(rate_x, dt), hit);
      cur_y = clamp_coord(y + scaled_by_dt(rate_y, dt), hit);
      cur_z = clamp_coord(z + scaled_by_dt(rate_z, dt), hit);
    end
    p.x = cur_x;
    p.y = cur_y;
    p.z = cur_z;
    p.saturated = hit;
  endtask

  // Watch register writes and both channels at every rising edge.
  always @(posedge clk) begin : watch
    position_t got, want;
    if (rst) begin
      sigma_r   = coord_t'(10 <<< FRAC_BITS);
      rho_r     = coord_t'(28 <<< FRAC_BITS);
      beta_r    = coord_t'((16 * (1 <<< FRAC_BITS) + 3) / 6);
      start_x_r = coord_t'(1 <<< FRAC_BITS);
      start_y_r = coord_t'(1 <<< FRAC_BITS);
      start_z_r = coord_t'(1 <<< FRAC_BITS);
      cur_x = start_x_r;
      cur_y = start_y_r;
      cur_z = start_z_r;
      expected_positions.delete();
      errors     = 0;
      checked_n  = 0;
      restarts_n = 0;
      clamps_n   = 0;
    end else begin
      // Register writes; unknown indexes are ignored.
      if (cfg_we) begin
        case (cfg_index)
          REG_SIGMA:   sigma_r   = cfg_data;
          REG_RHO:     rho_r     = cfg_data;
          REG_BETA:    beta_r    = cfg_data;
          REG_START_X: start_x_r = cfg_data;
          REG_START_Y: start_y_r = cfg_data;
          REG_START_Z: start_z_r = cfg_data;
          default: ;
        endcase
      end

      // A result transfer is compared with the oldest predicted position.
      if (result.valid && result.ready) begin
        got.x = result.pos_x;
        got.y = result.pos_y;
        got.z = result.pos_z;
        got.saturated = result.saturated;
        if (expected_positions.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("%0t: result with none predicted: x=%h y=%h z=%h sat=%b",
                     $realtime, got.x, got.y, got.z, got.saturated);
          end
        end else begin
          want = expected_positions.pop_front();
          checked_n++;
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.saturated !== want.saturated) begin
            errors++;
            if (errors <= 10) begin
              $display("%0t: result %0d differs: expected x=%h y=%h z=%h sat=%b",
                       $realtime, checked_n, want.x, want.y, want.z, want.saturated);
              $display("%0t: result %0d differs: actual   x=%h y=%h z=%h sat=%b",
                       $realtime, checked_n, got.x, got.y, got.z, got.saturated);
            end
          end
        end
      end

      // A step transfer advances the shadow position.
      if (step.valid && step.ready) begin
        euler_advance(step.step_size, step.restart, want);
        if (step.restart) restarts_n++;
        if (want.saturated) clamps_n++;
        expected_positions.insert(expected_positions.size(), want);
      end
    end
    mismatch_count  <= errors;
    outstanding     <= expected_positions.size();
    results_checked <= checked_n;
    restarts_seen   <= restarts_n;
    clamps_seen     <= clamps_n;
  end

endmodule

[bench/lorenz_euler_integrator_core_tb.sv]
// Testbench top for the Lorenz integrator: drives steps and register writes, gives the verdict.
`timescale 1ns / 1ps
module lorenz_euler_integrator_core_tb;
  import lei_pkg::*;

  typedef logic signed [CW-1:0] coord_t;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_STALLS} sink_mode_t;
  typedef enum int {PHASE_LORENZ, PHASE_WILD, PHASE_CORNER} phase_kind_t;

  localparam coord_t Q_ONE = coord_t'(1 <<< 24);
  localparam coord_t Q_MAX = 32'sh7fffffff;
  localparam coord_t Q_MIN = 32'sh80000000;
  localparam coord_t Q_ZERO = 32'sh0;
  // Indexes past the last register; writes to them must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;
  localparam logic [STEP_W-1:0] DT_MAX = '1;
  localparam logic [STEP_W-1:0] DT_FINE_MAX = 24'h03FFFF;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS = 50;
  localparam int DRAIN_CYCLES = 25;
  localparam int CYCLE_LIMIT = 400000;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CW-1:0]        cfg_data;

  int mismatch_count, outstanding, results_checked, restarts_seen, clamps_seen;
  int cycle_count = 0;
  int burst_left;
  int settings_used;

  lei_in_if  step_if ();
  lei_out_if result_if ();

  lorenz_euler_integrator_core u_top (
    .clk       (clk),
    .rst       (rst),
    .step      (step_if),
    .result    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lorenz_euler_integrator_core_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .step            (step_if),
    .result          (result_if),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .restarts_seen   (restarts_seen),
    .clamps_seen     (clamps_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Give up when the run takes far longer than any correct run could.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results still due.",
               cycle_count, outstanding);
      $display("lorenz_euler_integrator_core: mismatch");
      $finish;
    end
  end

  // Result receiver: switches between always ready, coin flips and long stalls.
  initial begin : sink_pattern
    sink_mode_t mode;
    int         hold;
    int         stall;
    result_if.ready = 1'b0;
    mode  = SINK_OPEN;
    hold  = 0;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        mode = sink_mode_t'($urandom_range(0, 2));
        hold = $urandom_range(50, 300);
      end
      hold--;
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        stall--;
      end else begin
        case (mode)
          SINK_OPEN: result_if.ready <= 1'b1;
          SINK_COIN: result_if.ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 5) == 0) begin
              stall = $urandom_range(1, 40);
              result_if.ready <= 1'b0;
            end else begin
              result_if.ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Offer one step item and hold it until its transfer; items come in bursts.
  task automatic send_step(input logic [STEP_W-1:0] dt, input logic reload);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        step_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    step_if.valid     <= 1'b1;
    step_if.step_size <= dt;
    step_if.restart   <= reload;
    @(posedge clk);
    while (!step_if.ready) @(posedge clk);
    burst_left--;
  endtask

  // Stop sending and wait until every predicted position has come back.
  task automatic drain_results();
    step_if.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input coord_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // Write all six registers on consecutive cycles.
  task automatic load_regs(input coord_t s, input coord_t r, input coord_t b,
                           input coord_t sx, input coord_t sy, input coord_t sz);
    write_reg(REG_SIGMA, s);
    write_reg(REG_RHO, r);
    write_reg(REG_BETA, b);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  function automatic coord_t corner_value();
    case ($urandom_range(0, 5))
      0: return Q_MIN;
      1: return Q_MAX;
      2: return Q_ZERO;
      3: return -coord_t'(1);
      4: return Q_ONE;
      default: return -Q_ONE;
    endcase
  endfunction

  function automatic coord_t near_value(input int base, input int spread);
    return coord_t'(base + int'($urandom_range(0, 2 * spread)) - spread);
  endfunction

  initial begin : stimulus
    phase_kind_t       kind;
    logic [STEP_W-1:0] dt;
    logic              reload;
    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    step_if.valid     = 1'b0;
    step_if.step_size = '0;
    step_if.restart   = 1'b0;
    burst_left        = 0;
    settings_used     = 1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default coefficients: zero step, extreme steps, restart with a junk step size.
    send_step('0, 1'b0);
    send_step(DT_MAX, 1'b0);
    send_step(24'h000001, 1'b0);
    send_step(24'hA5A5A5, 1'b1);
    send_step(24'h028F5C, 1'b0);
    send_step(24'h028F5C, 1'b0);
    send_step(24'h5A5A5A, 1'b0);
    send_step('0, 1'b1);
    drain_results();

    // Extreme registers, plus writes to the unused indexes.
    load_regs(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN);
    @(posedge clk);
    write_reg(REG_SPARE_A, coord_t'($urandom));
    write_reg(REG_SPARE_B, -coord_t'(1));
    cfg_we <= 1'b0;
    send_step(24'h123456, 1'b1);
    send_step(DT_MAX, 1'b0);
    send_step(DT_MAX, 1'b0);
    send_step('0, 1'b0);
    send_step(24'h800000, 1'b0);
    drain_results();

    load_regs(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_ZERO);
    send_step(DT_MAX, 1'b1);
    send_step(DT_MAX, 1'b0);
    send_step(DT_MAX, 1'b0);
    send_step(24'h7FFFFF, 1'b0);
    drain_results();

    // All zero: the position must stay at the origin.
    load_regs(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO);
    send_step(DT_MAX, 1'b1);
    send_step(DT_MAX, 1'b0);

    // Random phases; about half follow a true Lorenz trajectory with a small step.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain_results();
      case ($urandom_range(0, 5))
        0, 1, 2: kind = PHASE_LORENZ;
        3, 4:    kind = PHASE_WILD;
        default: kind = PHASE_CORNER;
      endcase
      case (kind)
        PHASE_LORENZ: load_regs(near_value(10 <<< 24, 1 <<< 24),
                                near_value(28 <<< 24, 1 <<< 24),
                                near_value(44739243, 1 <<< 22),
                                near_value(0, 20 <<< 24),
                                near_value(0, 20 <<< 24),
                                near_value(0, 20 <<< 24));
        PHASE_WILD:   load_regs(coord_t'($urandom), coord_t'($urandom),
                                coord_t'($urandom), coord_t'($urandom),
                                coord_t'($urandom), coord_t'($urandom));
        default:      load_regs(corner_value(), corner_value(), corner_value(),
                                corner_value(), corner_value(), corner_value());
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case (kind)
          PHASE_LORENZ: begin
            reload = (i == 0) || ($urandom_range(0, 24) == 0);
            dt = ($urandom_range(0, 9) == 0) ? STEP_W'($urandom)
                                             : STEP_W'($urandom_range(0, DT_FINE_MAX));
          end
          PHASE_WILD: begin
            reload = (i == 0) || ($urandom_range(0, 5) == 0);
            dt = STEP_W'($urandom);
          end
          default: begin
            reload = (i == 0) || ($urandom_range(0, 3) == 0);
            dt = ($urandom_range(0, 2) == 0) ? DT_MAX : STEP_W'($urandom);
          end
        endcase
        send_step(dt, reload);
        // Now and then the sender holds off until the block has caught up.
        if ($urandom_range(0, 99) == 0) drain_results();
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d positions under %0d register settings.",
             results_checked, settings_used);
    $display("The run held %0d restarts and %0d clamped steps.", restarts_seen, clamps_seen);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("lorenz_euler_integrator_core: match");
    end else begin
      $display("lorenz_euler_integrator_core: mismatch");
    end
    $finish;
  end

endmodule

[lorenz_euler_integrator_core.f]
rtl/core/lei_pkg.sv
rtl/core/lei_in_if.sv
rtl/core/lei_out_if.sv
rtl/core/lei_cfg.sv
rtl/core/lei_seq.sv
rtl/core/lei_mul.sv
rtl/core/lei_dp.sv
rtl/core/lorenz_euler_integrator_core.sv
bench/lorenz_euler_integrator_core_checker.sv
bench/lorenz_euler_integrator_core_tb.sv
